// File: design/slte_pkg.sv
package slte_pkg;

    // APB configuration space
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // Register index as decoded from paddr[2]
    localparam logic CFG_IDX_FLIP_SCREEN = 1'b0;

    // Position arithmetic is done 12 bits wide, then cut to 11
    localparam int unsigned POS_W = 12;
    localparam int unsigned SCR_W = 11;

    localparam logic [POS_W-1:0] X_OFFSET       = 12'd256;
    localparam logic [POS_W-1:0] Y_ORIGIN       = 12'd384;
    localparam logic [POS_W-1:0] X_FLIP_ORIGIN  = 12'd768;
    localparam logic [POS_W-1:0] Y_FLIP_OFFSET  = 12'd100;
    localparam logic [POS_W-1:0] TILE_PIX       = 12'd16;

    // Attribute word fields
    localparam int unsigned ATTR_COLOR_LSB = 0;
    localparam int unsigned ATTR_FLIPY_BIT = 10;
    localparam int unsigned ATTR_FLIPX_BIT = 11;
    localparam int unsigned ATTR_LOGH_LSB  = 12;
    localparam int unsigned ATTR_LOGW_LSB  = 14;

    typedef struct packed {
        logic load_entry;
        logic skip_entry;
        logic emit_tile;
    } slte_cmd_t;

    typedef struct packed {
        logic entry_expands;
        logic slot_free;
        logic tile_last;
    } slte_status_t;

endpackage

// File: design/slte_ctrl.sv
module slte_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  slte_pkg::slte_status_t status,
    output slte_pkg::slte_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        cmd.load_entry = 1'b0;
        cmd.skip_entry = 1'b0;
        cmd.emit_tile  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.entry_expands)
                    begin
                        cmd.load_entry = 1'b1;
                        state_next     = ST_RUN;
                        in_ready_next  = 1'b0;
                    end
                    else
                    begin
                        cmd.skip_entry = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_tile = 1'b1;
                    if (status.tile_last)
                    begin
                        state_next    = ST_IDLE;
                        in_ready_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: design/slte_datapath.sv
module slte_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flip_screen,
    input  logic                          list_start,
    input  logic [15:0]                   y_word,
    input  logic [15:0]                   code_word,
    input  logic [15:0]                   attr_word,
    input  logic [15:0]                   x_word,
    input  slte_pkg::slte_cmd_t           cmd,
    output slte_pkg::slte_status_t        status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   tile_code,
    output logic [3:0]                    color,
    output logic                          flip_x,
    output logic                          flip_y,
    output logic signed [slte_pkg::SCR_W-1:0] screen_x,
    output logic signed [slte_pkg::SCR_W-1:0] screen_y,
    output logic                          last
);

    // Skip counter
    logic [2:0] skip_reg;
    logic [2:0] skip_next;
    logic [2:0] skip_eff;

    // Latched entry
    logic [15:0]                   base_reg;
    logic [3:0]                    color_reg;
    logic                          fx_reg;
    logic                          fy_reg;
    logic [2:0]                    wmask_reg;
    logic [2:0]                    hmask_reg;
    logic [slte_pkg::POS_W-1:0]    sx_reg;
    logic [slte_pkg::POS_W-1:0]    sy_reg;
    logic [2:0]                    col_reg;
    logic [2:0]                    row_reg;

    // Output stage
    logic                          out_valid_reg;
    logic [15:0]                   tile_code_reg;
    logic [3:0]                    color_out_reg;
    logic                          fx_out_reg;
    logic                          fy_out_reg;
    logic [slte_pkg::SCR_W-1:0]    sx_out_reg;
    logic [slte_pkg::SCR_W-1:0]    sy_out_reg;
    logic                          last_reg;

    // Decoded entry
    logic [1:0]                    log_w;
    logic [1:0]                    log_h;
    logic [slte_pkg::POS_W-1:0]    w_pix;
    logic [slte_pkg::POS_W-1:0]    h_pix;
    logic [slte_pkg::POS_W-1:0]    xpos;
    logic [slte_pkg::POS_W-1:0]    ypos;
    logic [slte_pkg::POS_W-1:0]    sx_start;
    logic [slte_pkg::POS_W-1:0]    sy_start;
    logic [2:0]                    wmask;
    logic [2:0]                    hmask;

    // Current tile
    logic [2:0]                    col_code;
    logic [2:0]                    row_code;
    logic [15:0]                   code_cur;
    logic [slte_pkg::POS_W-1:0]    px_cur;
    logic [slte_pkg::POS_W-1:0]    py_cur;
    logic                          at_last;

    assign skip_eff = list_start ? 3'd0 : skip_reg;

    assign log_w = attr_word[slte_pkg::ATTR_LOGW_LSB +: 2];
    assign log_h = attr_word[slte_pkg::ATTR_LOGH_LSB +: 2];
    assign wmask = 3'((4'd1 << log_w) - 4'd1);
    assign hmask = 3'((4'd1 << log_h) - 4'd1);
    assign w_pix = slte_pkg::TILE_PIX << log_w;
    assign h_pix = slte_pkg::TILE_PIX << log_h;
    assign xpos  = slte_pkg::POS_W'(x_word[9:0]);
    assign ypos  = slte_pkg::POS_W'(y_word[8:0]);

    // Flip screen: x' = 768 - 16w - xpos, y' = ypos - 100
    always_comb
    begin
        if (flip_screen)
        begin
            sx_start = slte_pkg::X_FLIP_ORIGIN - w_pix - xpos;
            sy_start = ypos - slte_pkg::Y_FLIP_OFFSET;
        end
        else
        begin
            sx_start = xpos - slte_pkg::X_OFFSET;
            sy_start = slte_pkg::Y_ORIGIN - ypos - h_pix;
        end
    end

    // Mirror column/row by XOR with the mask: w-1-c == ~c & (w-1)
    assign col_code = col_reg ^ (fx_reg ? wmask_reg : 3'd0);
    assign row_code = row_reg ^ (fy_reg ? hmask_reg : 3'd0);
    assign code_cur = base_reg + {10'd0, col_code, row_code};
    assign px_cur   = sx_reg + {5'd0, col_reg, 4'd0};
    assign py_cur   = sy_reg + {5'd0, row_reg, 4'd0};
    assign at_last  = (col_reg == wmask_reg) && (row_reg == hmask_reg);

    always_comb
    begin
        skip_next = skip_reg;
        if (cmd.skip_entry)
            skip_next = skip_eff - 3'd1;
        else if (cmd.load_entry)
            skip_next = wmask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            skip_reg <= skip_next;
            if (cmd.emit_tile)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            base_reg  <= code_word;
            color_reg <= attr_word[slte_pkg::ATTR_COLOR_LSB +: 4];
            fx_reg    <= attr_word[slte_pkg::ATTR_FLIPX_BIT] ^ flip_screen;
            fy_reg    <= attr_word[slte_pkg::ATTR_FLIPY_BIT] ^ flip_screen;
            wmask_reg <= wmask;
            hmask_reg <= hmask;
            sx_reg    <= sx_start;
            sy_reg    <= sy_start;
            col_reg   <= 3'd0;
            row_reg   <= 3'd0;
        end
        else if (cmd.emit_tile)
        begin
            // rows inner, columns outer
            if (row_reg == hmask_reg)
            begin
                row_reg <= 3'd0;
                col_reg <= col_reg + 3'd1;
            end
            else
            begin
                row_reg <= row_reg + 3'd1;
            end
        end

        if (cmd.emit_tile)
        begin
            tile_code_reg <= code_cur;
            color_out_reg <= color_reg;
            fx_out_reg    <= fx_reg;
            fy_out_reg    <= fy_reg;
            sx_out_reg    <= px_cur[slte_pkg::SCR_W-1:0];
            sy_out_reg    <= py_cur[slte_pkg::SCR_W-1:0];
            last_reg      <= at_last;
        end
    end

    assign status.entry_expands = (skip_eff == 3'd0);
    assign status.slot_free     = !out_valid_reg || out_ready;
    assign status.tile_last     = at_last;

    assign out_valid = out_valid_reg;
    assign tile_code = tile_code_reg;
    assign color     = color_out_reg;
    assign flip_x    = fx_out_reg;
    assign flip_y    = fy_out_reg;
    assign screen_x  = sx_out_reg;
    assign screen_y  = sy_out_reg;
    assign last      = last_reg;

endmodule

// File: design/sprite_list_tile_expander.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// entry in  | in_valid / in_ready  | list_start, y_word, code_word, attr_word, x_word
// tile out  | out_valid / out_ready| tile_code, color, flip_x, flip_y, screen_x,
//           |                      | screen_y, last
// config    | APB psel/penable     | flip_screen at byte address 0
//
// An expanded entry is accepted and then yields w*h tile commands (1 to 64),
// one per cycle while the output is not stalled, paced by the row/column
// counters in the datapath. A skipped entry produces no transaction.
// rst_n clears the skip count, flip_screen and the output valid at once.
// A stalled output holds the tile register and freezes the counters; the
// next entry is taken while the last tile of the previous one still waits.
module sprite_list_tile_expander (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slte_pkg::ADDR_W-1:0]   paddr,
    input  logic [slte_pkg::DATA_W-1:0]   pwdata,
    output logic [slte_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // sprite list entries
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          list_start,
    input  logic [15:0]                   y_word,
    input  logic [15:0]                   code_word,
    input  logic [15:0]                   attr_word,
    input  logic [15:0]                   x_word,
    // tile commands
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   tile_code,
    output logic [3:0]                    color,
    output logic                          flip_x,
    output logic                          flip_y,
    output logic signed [slte_pkg::SCR_W-1:0] screen_x,
    output logic signed [slte_pkg::SCR_W-1:0] screen_y,
    output logic                          last
);

    logic                   flip_screen_reg;
    logic                   cfg_write;
    slte_pkg::slte_cmd_t    cmd;
    slte_pkg::slte_status_t status;

    // Register write completes in the APB access phase; paddr[2] picks the word
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flip_screen_reg <= 1'b0;
        else if (cfg_write && (paddr[2] == slte_pkg::CFG_IDX_FLIP_SCREEN))
            flip_screen_reg <= pwdata[0];
    end

    // Read back; words beyond the register list read as zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == slte_pkg::CFG_IDX_FLIP_SCREEN)
            prdata[0] = flip_screen_reg;
    end

    // Sequencer: accept or skip entries, then step through the tiles
    slte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Entry registers, tile counters, position/code arithmetic, output stage
    slte_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .flip_screen (flip_screen_reg),
        .list_start  (list_start),
        .y_word      (y_word),
        .code_word   (code_word),
        .attr_word   (attr_word),
        .x_word      (x_word),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tile_code   (tile_code),
        .color       (color),
        .flip_x      (flip_x),
        .flip_y      (flip_y),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .last        (last)
    );

endmodule

// File: design/slte_checker.sv
module slte_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [slte_pkg::ADDR_W-1:0]   paddr,
    input logic [slte_pkg::DATA_W-1:0]   pwdata,
    input logic [slte_pkg::DATA_W-1:0]   prdata,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [15:0]                   tile_code,
    input logic [3:0]                    color,
    input logic                          flip_x,
    input logic                          flip_y,
    input logic [slte_pkg::SCR_W-1:0]    screen_x,
    input logic                          last
);

    // Stalled tile holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tile_code) && $stable(screen_x))
        else $error("stalled tile command changed");

    // While an entry is mid-expansion, no new entry is taken
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("entry accepted during expansion");

    // Tiles of one entry follow back to back with shared attributes
    a_entry_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            out_valid && $stable(color) && $stable(flip_x) && $stable(flip_y))
        else $error("entry expansion broke off or attributes changed");

    // Written flip_screen reads back
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[2] == slte_pkg::CFG_IDX_FLIP_SCREEN) |=>
            (paddr[2] != slte_pkg::CFG_IDX_FLIP_SCREEN) || (prdata[0] == $past(pwdata[0])))
        else $error("flip_screen readback mismatch");

endmodule

bind sprite_list_tile_expander slte_checker u_slte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tile_code (tile_code),
    .color     (color),
    .flip_x    (flip_x),
    .flip_y    (flip_y),
    .screen_x  (screen_x),
    .last      (last)
);
